@@ sv/rnts_pkg.sv @@
// ----------------------------------------------------------------------------
// rnts_pkg
// Shared types, codes and helpers of the trainable relu neuron: request and
// result structs, request and register codes, sequencer states, saturation.
// ----------------------------------------------------------------------------
package rnts_pkg;

  // default vector depth
  localparam int MAX_INPUTS_DEF = 64;

  // field and register widths
  localparam int REQ_W      = 3;
  localparam int ELEM_W     = 6;
  localparam int DATA_W     = 32;
  localparam int ACTIVE_W   = 7;
  localparam int LR_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // arithmetic widths
  localparam int PROD_W = 65;  // 33 x 32 signed product
  localparam int LRD_W  = 33;  // floored lr * delta
  localparam int ACC_W  = 58;  // exact forward sum of floored products
  localparam int SAT_W  = 66;  // common input width of the saturator

  // reset values of the registers
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;
  localparam logic [LR_W-1:0]     LR_RST     = 16'd655;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_LAYER   = 2'd2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_WR_INPUT  = 3'd0,
    REQ_WR_WEIGHT = 3'd1,
    REQ_WR_BIAS   = 3'd2,
    REQ_FORWARD   = 3'd3,
    REQ_BACKWARD  = 3'd4
  } req_e;

  // result kinds
  localparam logic KIND_ACT  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FWD,
    S_FWD_OUT,
    S_B_LR,
    S_B_LRD,
    S_B_MUL1,
    S_B_MUL2,
    S_B_UPD
  } state_e;

  // request item
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [ELEM_W-1:0]        elem_index;
    logic signed [DATA_W-1:0] data_value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                     result_kind;
    logic [ELEM_W-1:0]        result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     last_result;
  } out_item_t;

  // clamp a wide signed value to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[SAT_W-1:DATA_W-1]) || ~(|v[SAT_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ sv/rnts_ram.sv @@
// ----------------------------------------------------------------------------
// rnts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rnts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/relu_neuron_train_step.sv @@
// ----------------------------------------------------------------------------
// relu_neuron_train_step
// Trainable neuron in signed Q16.16: element and bias loads, forward pass
// with relu or identity, backward pass with gradient output and sgd update.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  request   in_valid_i, in_ready_o, in_data_i         in
//  result    out_valid_o, out_ready_i, out_data_o      out
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          in
//
//  Forward and backward items walk the n active elements in turn; the one
//  shared 33x32 multiplier forms one product per element forward and two
//  per element backward, and the weight ram is read and written back.
//  The block takes one item at a time; in_ready_o is high only when idle.
//  A stalled result holds the sequencer at the point where it loads the
//  output register. Reset clears control, registers, bias and last sum;
//  the input and weight memories are not cleared.
//
module relu_neuron_train_step
  import rnts_pkg::*;
#(
  parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int MAX_N_I = (MAX_INPUTS < 127) ? MAX_INPUTS : 127;
  localparam logic [ACTIVE_W-1:0] MAX_N = ACTIVE_W'(MAX_N_I);

  // configuration registers
  logic [ACTIVE_W-1:0] active_q;
  logic [LR_W-1:0]     lr_q;
  logic                final_q;

  // sequencer and datapath registers
  state_e                   state_q, state_d;
  logic [ACTIVE_W-1:0]      i_q, i_d;
  logic [ACTIVE_W-1:0]      n_q, n_d;
  logic                     fv_q, fv_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] delta_q, delta_d;
  logic signed [LRD_W-1:0]  lr_delta_q, lr_delta_d;
  logic signed [DATA_W-1:0] w_q, w_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] g_q, g_d;
  logic signed [DATA_W-1:0] bias_q, bias_d;
  logic signed [DATA_W-1:0] last_sum_q, last_sum_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;

  // shared multiplier
  logic signed [LRD_W-1:0]  mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // memory ports
  logic                     in_ram_we;
  logic                     wt_ram_we;
  logic [AW-1:0]            wt_waddr;
  logic signed [DATA_W-1:0] wt_wdata;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] w_rd;
  logic signed [DATA_W-1:0] x_rd;

  // misc
  logic                     in_fire;
  logic                     out_free;
  logic                     elem_ok;
  logic                     is_last;
  logic signed [DATA_W-1:0] fwd_sum;
  logic signed [DATA_W-1:0] step;
  logic [ACTIVE_W-1:0]      n_calc;

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign elem_ok     = int'(in_data_i.elem_index) < MAX_INPUTS;
  assign is_last     = (i_q == n_q - ACTIVE_W'(1));
  assign raddr       = AW'(i_d);

  // element count: zero acts as one, clamp to the store depth
  assign n_calc = (active_q == '0) ? ACTIVE_W'(1) :
                  (active_q > MAX_N) ? MAX_N : active_q;

  // forward sum plus bias, saturated once
  assign fwd_sum = sat32(SAT_W'(acc_q) + SAT_W'(bias_q));

  // sgd step for the current element
  assign step = sat32(SAT_W'(prod_q >>> 16));

  assign in_ram_we = in_fire && (in_data_i.req_type == REQ_WR_INPUT) && elem_ok;

  rnts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_INPUTS),
    .AW    (AW)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (in_ram_we),
    .waddr_i (AW'(in_data_i.elem_index)),
    .wdata_i (in_data_i.data_value),
    .raddr_i (raddr),
    .rdata_o (x_rd)
  );

  rnts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_INPUTS),
    .AW    (AW)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wt_ram_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .raddr_i (raddr),
    .rdata_o (w_rd)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    n_d         = n_q;
    fv_d        = 1'b0;
    acc_d       = acc_q;
    prod_d      = prod_q;
    delta_d     = delta_q;
    lr_delta_d  = lr_delta_q;
    w_d         = w_q;
    x_d         = x_q;
    g_d         = g_q;
    bias_d      = bias_q;
    last_sum_d  = last_sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    wt_ram_we   = 1'b0;
    wt_waddr    = AW'(in_data_i.elem_index);
    wt_wdata    = in_data_i.data_value;

    // accumulate the product of the previous forward element
    if (fv_q) begin
      acc_d = acc_q + ACC_W'(prod_q >>> 16);
    end

    case (state_q)
      S_IDLE: begin
        i_d   = '0;
        acc_d = '0;
        if (in_fire) begin
          n_d = n_calc;
          case (in_data_i.req_type)
            REQ_WR_WEIGHT: begin
              wt_ram_we = elem_ok;
            end
            REQ_WR_BIAS: begin
              bias_d = in_data_i.data_value;
            end
            REQ_FORWARD: begin
              state_d = S_FWD;
            end
            REQ_BACKWARD: begin
              delta_d = (final_q || (last_sum_q > 0)) ? in_data_i.data_value : '0;
              state_d = S_B_LR;
            end
            default: begin
            end
          endcase
        end
      end

      // one element per cycle into the multiplier
      S_FWD: begin
        mul_a = LRD_W'(w_rd);
        mul_b = x_rd;
        if (i_q != n_q) begin
          prod_d = mul_p;
          fv_d   = 1'b1;
          i_d    = i_q + ACTIVE_W'(1);
        end else if (!fv_q) begin
          state_d = S_FWD_OUT;
        end
      end

      // add bias, store the sum, emit the activation
      S_FWD_OUT: begin
        if (out_free) begin
          last_sum_d             = fwd_sum;
          out_valid_d            = 1'b1;
          out_d.result_kind      = KIND_ACT;
          out_d.result_index     = '0;
          out_d.result_value     = (!final_q && fwd_sum[DATA_W-1]) ? '0 : fwd_sum;
          out_d.last_result      = 1'b1;
          state_d                = S_IDLE;
        end
      end

      // lr * delta
      S_B_LR: begin
        mul_a   = LRD_W'(delta_q);
        mul_b   = DATA_W'({1'b0, lr_q});
        prod_d  = mul_p;
        state_d = S_B_LRD;
      end

      S_B_LRD: begin
        lr_delta_d = LRD_W'(prod_q >>> 16);
        state_d    = S_B_MUL1;
      end

      // delta * old weight
      S_B_MUL1: begin
        w_d     = w_rd;
        x_d     = x_rd;
        mul_a   = LRD_W'(delta_q);
        mul_b   = w_rd;
        prod_d  = mul_p;
        state_d = S_B_MUL2;
      end

      // gradient out of the first product, lr_delta * input next
      S_B_MUL2: begin
        g_d     = sat32(SAT_W'(prod_q >>> 16));
        mul_a   = lr_delta_q;
        mul_b   = x_q;
        prod_d  = mul_p;
        state_d = S_B_UPD;
      end

      // emit gradient, write back the weight, update the bias on the last element
      S_B_UPD: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.result_kind  = KIND_GRAD;
          out_d.result_index = i_q[ELEM_W-1:0];
          out_d.result_value = g_q;
          out_d.last_result  = is_last;
          wt_ram_we          = 1'b1;
          wt_waddr           = AW'(i_q);
          wt_wdata           = sat32(SAT_W'(w_q) - SAT_W'(step));
          if (is_last) begin
            bias_d  = sat32(SAT_W'(bias_q) - SAT_W'(lr_delta_q));
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + ACTIVE_W'(1);
            state_d = S_B_MUL1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers, configuration, bias and last sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ACTIVE_RST;
      lr_q        <= LR_RST;
      final_q     <= 1'b0;
      i_q         <= '0;
      n_q         <= '0;
      fv_q        <= 1'b0;
      bias_q      <= '0;
      last_sum_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      n_q         <= n_d;
      fv_q        <= fv_d;
      bias_q      <= bias_d;
      last_sum_q  <= last_sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_INPUTS: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
          CFG_LEARNING_RATE: lr_q     <= cfg_wdata_i[LR_W-1:0];
          CFG_FINAL_LAYER:   final_q  <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    delta_q    <= delta_d;
    lr_delta_q <= lr_delta_d;
    w_q        <= w_d;
    x_q        <= x_d;
    g_q        <= g_d;
    out_q      <= out_d;
  end

  // forward results carry index zero and close their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == KIND_ACT) |->
      (out_data_o.result_index == '0) && out_data_o.last_result)
    else $error("forward result with bad index or last flag");

  // the forward walk never runs past the element count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWD) |-> (i_q <= n_q))
    else $error("forward element counter past count");

  // a forward transfer starts the forward walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.req_type == REQ_FORWARD) |=> (state_q == S_FWD))
    else $error("forward request did not start the walk");

  // weight writes happen only on load or during the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wt_ram_we |-> (state_q == S_IDLE) || (state_q == S_B_UPD))
    else $error("weight write outside load or update");

endmodule
